[design/skf_pkg.sv]
`timescale 1ns / 1ps

package skf_pkg;

    localparam int ALPHABET_SIZE = 26;
    localparam int LETTER_W      = 5;
    localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(ALPHABET_SIZE - 1);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic count_en;
        logic load_ref;
        logic cmp_step;
        logic clear_counts;
        logic emit_load;
    } skf_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic m_last;
        logic l_last;
        logic p_last;
        logic out_free;
    } skf_sts_t;

    // Rank position that the English frequency order assigns to a plaintext letter
    function automatic logic [LETTER_W-1:0] rank_of_plain(input logic [LETTER_W-1:0] p);
        logic [LETTER_W-1:0] r;
        case (p)
            5'd0:    r = 5'd3;
            5'd1:    r = 5'd19;
            5'd2:    r = 5'd11;
            5'd3:    r = 5'd9;
            5'd4:    r = 5'd0;
            5'd5:    r = 5'd15;
            5'd6:    r = 5'd17;
            5'd7:    r = 5'd8;
            5'd8:    r = 5'd5;
            5'd9:    r = 5'd24;
            5'd10:   r = 5'd21;
            5'd11:   r = 5'd10;
            5'd12:   r = 5'd14;
            5'd13:   r = 5'd4;
            5'd14:   r = 5'd2;
            5'd15:   r = 5'd18;
            5'd16:   r = 5'd23;
            5'd17:   r = 5'd6;
            5'd18:   r = 5'd7;
            5'd19:   r = 5'd1;
            5'd20:   r = 5'd13;
            5'd21:   r = 5'd20;
            5'd22:   r = 5'd12;
            5'd23:   r = 5'd22;
            5'd24:   r = 5'd16;
            5'd25:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

[design/substitution_key_from_letter_frequency_top.sv]
`timescale 1ns / 1ps

// Substitution key guess by ciphertext letter frequency.
// Input stream: one ciphertext letter per beat in s_tdata[4:0] (0 = A .. 25 = Z),
// s_tlast on the final letter of a message. Letters 26..31 are ignored but a
// tlast on them still closes the message. Letters are taken one per cycle while s_tready is high.
// Each letter count saturates at 2^COUNT_BITS - 1.
// After the tlast beat the block ranks the 26 letters, highest count first,
// lower letter first on a tie; the ranking visits every pair of letters over
// one shared histogram read port. Then 26 key beats follow at one per cycle
// while m_tready is high, plain letters 0..25 in order, m_tlast on letter 25.
// s_tready is low from the tlast beat until the last key beat is loaded into
// the output register; the next message may start while that beat waits.
// A stalled receiver holds the current key beat and stops the key sequence.
// Reset (aresetn low, synchronous) clears the histogram and the control state;
// counts are also cleared at the end of every ranking.
module substitution_key_from_letter_frequency_top #(
    parameter int COUNT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [4:0] cipher_letter_in, [7:5] zero
    input  logic        s_tlast,   // message_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [4:0] plain_letter, [9:5] mapped_cipher_letter, [15:10] zero
    output logic        m_tlast    // key_last
);

    skf_pkg::skf_cmd_t cmd;
    skf_pkg::skf_sts_t sts;

    logic [skf_pkg::LETTER_W-1:0] plain_letter;
    logic [skf_pkg::LETTER_W-1:0] mapped_letter;

    skf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    skf_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .letter_in     (s_tdata[4:0]),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .plain_letter  (plain_letter),
        .mapped_letter (mapped_letter),
        .key_last      (m_tlast)
    );

    assign m_tdata = {6'd0, mapped_letter, plain_letter};

    // Last key beat always carries plain letter Z
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[4:0] == skf_pkg::LAST_LETTER))
        else $error("key_last on a plain letter other than Z");

    // Key beats follow each other without gaps
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("gap inside the key sequence");

    // Plain letters advance by one per key beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
        (m_tdata[4:0] == 5'($past(m_tdata[4:0]) + 5'd1)))
        else $error("plain letter sequence broken");

    // Input closes while the ranking runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input accepted right after message end");

endmodule

[design/skf_ctrl.sv]
`timescale 1ns / 1ps

module skf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tlast,
    output logic              s_tready,
    input  skf_pkg::skf_sts_t sts,
    output skf_pkg::skf_cmd_t cmd
);

    localparam logic [1:0] ST_COUNT = 2'd0;
    localparam logic [1:0] ST_LOAD  = 2'd1;
    localparam logic [1:0] ST_CMP   = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_COUNT: begin
                s_tready     = 1'b1;
                cmd.count_en = s_tvalid;
                if (s_tvalid && s_tlast) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load_ref = 1'b1;
                state_next   = ST_CMP;
            end
            ST_CMP: begin
                cmd.cmp_step = 1'b1;
                if (sts.m_last) begin
                    if (sts.l_last) begin
                        cmd.clear_counts = 1'b1;
                        state_next       = ST_EMIT;
                    end else begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit_load = 1'b1;
                    if (sts.p_last) begin
                        state_next = ST_COUNT;
                    end
                end
            end
            default: begin
                state_next = ST_COUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_COUNT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[design/skf_datapath.sv]
`timescale 1ns / 1ps

module skf_datapath #(
    parameter int COUNT_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  skf_pkg::skf_cmd_t              cmd,
    output skf_pkg::skf_sts_t              sts,
    input  logic [skf_pkg::LETTER_W-1:0]   letter_in,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic [skf_pkg::LETTER_W-1:0]   plain_letter,
    output logic [skf_pkg::LETTER_W-1:0]   mapped_letter,
    output logic                           key_last
);

    localparam int LW = skf_pkg::LETTER_W;
    localparam int AS = skf_pkg::ALPHABET_SIZE;

    logic [COUNT_BITS-1:0] counts_reg [AS];
    logic [LW-1:0]         rank_reg   [AS];

    logic [COUNT_BITS-1:0] ref_reg;
    logic [LW-1:0]         l_reg;
    logic [LW-1:0]         m_reg;
    logic [LW-1:0]         pos_reg;
    logic [LW-1:0]         p_reg;
    logic                  valid_reg;
    logic [LW-1:0]         plain_reg;
    logic [LW-1:0]         mapped_reg;
    logic                  last_reg;

    logic [LW-1:0]         rd_addr;
    logic [COUNT_BITS-1:0] rd_data;
    logic                  ahead;
    logic [LW-1:0]         pos_next;

    // One read port into the histogram, shared by counting and ranking
    always_comb begin
        if (cmd.count_en) begin
            rd_addr = letter_in;
        end else if (cmd.load_ref) begin
            rd_addr = l_reg;
        end else begin
            rd_addr = m_reg;
        end
        rd_data = (rd_addr <= skf_pkg::LAST_LETTER) ? counts_reg[rd_addr] : '0;
    end

    // Letter m ranks ahead of letter l on a higher count, or a tie with a lower index
    assign ahead    = (rd_data > ref_reg) || ((rd_data == ref_reg) && (m_reg < l_reg));
    assign pos_next = pos_reg + {{(LW-1){1'b0}}, ahead};

    assign sts.m_last   = (m_reg == skf_pkg::LAST_LETTER);
    assign sts.l_last   = (l_reg == skf_pkg::LAST_LETTER);
    assign sts.p_last   = (p_reg == skf_pkg::LAST_LETTER);
    assign sts.out_free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < AS; i++) begin
                counts_reg[i] <= '0;
            end
        end else if (cmd.clear_counts) begin
            for (int i = 0; i < AS; i++) begin
                counts_reg[i] <= '0;
            end
        end else if (cmd.count_en && (letter_in <= skf_pkg::LAST_LETTER) && (rd_data != '1)) begin
            counts_reg[letter_in] <= rd_data + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l_reg     <= '0;
            m_reg     <= '0;
            pos_reg   <= '0;
            p_reg     <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (cmd.load_ref) begin
                m_reg   <= '0;
                pos_reg <= '0;
            end else if (cmd.cmp_step) begin
                m_reg   <= m_reg + 1'b1;
                pos_reg <= pos_next;
                if (sts.m_last) begin
                    l_reg <= sts.l_last ? '0 : l_reg + 1'b1;
                end
            end
            if (cmd.emit_load) begin
                p_reg     <= sts.p_last ? '0 : p_reg + 1'b1;
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_ref) begin
            ref_reg <= rd_data;
        end
        if (cmd.cmp_step && sts.m_last) begin
            rank_reg[pos_next] <= l_reg;
        end
        if (cmd.emit_load) begin
            plain_reg  <= p_reg;
            mapped_reg <= rank_reg[skf_pkg::rank_of_plain(p_reg)];
            last_reg   <= sts.p_last;
        end
    end

    assign m_tvalid      = valid_reg;
    assign plain_letter  = plain_reg;
    assign mapped_letter = mapped_reg;
    assign key_last      = last_reg;

endmodule
